[rtl/mpss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpss_pkg
// Shared types and constants for the shape perimeter maximum selector.
// ----------------------------------------------------------------------------
package mpss_pkg;

    localparam int MAX_ITEMS_DEF = 4096;

    localparam int COORD_W     = 16;
    localparam int INDEX_W     = 12;
    localparam int PERIM_W     = 27;
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 40;

    // circle: round(r * 2 * 3.1415 * 256) = r * CIRC_INT + floor(f / 125),
    // f = r * CIRC_FRAC_MUL + CIRC_FRAC_RND, divide done as multiply by
    // ceil(2^29 / 125) and shift, exact for f below 2^22
    localparam int CIRC_INT      = 1608;
    localparam int CIRC_FRAC_MUL = 56;
    localparam int CIRC_FRAC_RND = 62;
    localparam int CFRAC_W       = 22;
    localparam int CIRC_SHIFT    = 29;
    localparam logic [22:0] CIRC_RECIP = 23'd4294968;
    localparam int CPROD_W       = 45;
    localparam int CQ_W          = CPROD_W - CIRC_SHIFT;

    // side length: floor(sqrt(d2 << 16)), one root bit per step
    localparam int D2_W        = 33;
    localparam int RAD_W       = 50;
    localparam int ROOT_W      = 25;
    localparam int SQ_REM_W    = 26;
    localparam int SQRT_STEPS  = RAD_W / 2;

    localparam int ITER_W      = $clog2(SQRT_STEPS);

    typedef enum logic [1:0] {
        KIND_RECT   = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_TRI    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECT,
        S_CMUL,
        S_CDIV,
        S_CEND,
        S_SETUP,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_ACC,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic rect;
        logic cmul;
        logic div_step;
        logic div_end;
        logic tri_setup;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic acc_side;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic root_done;
        logic side_done;
    } t_sts;

endpackage

[rtl/mpss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpss_ctrl
// Sequencer: walks one shape through its perimeter steps, then the maximum
// update and, on the last shape, the hand-off into the output register.
// ----------------------------------------------------------------------------
module mpss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  mpss_pkg::t_kind  i_s_kind,
    input  logic             i_m_tready,
    input  mpss_pkg::t_sts   i_sts,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output mpss_pkg::t_cmd   o_cmd
);

    mpss_pkg::t_state r_state;
    mpss_pkg::t_state n_state;
    logic             r_out_valid;
    logic             can_emit;

    // output slot is free, or its result leaves at this edge
    assign can_emit = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpss_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mpss_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_s_kind)
                        mpss_pkg::KIND_RECT:   n_state = mpss_pkg::S_RECT;
                        mpss_pkg::KIND_CIRCLE: n_state = mpss_pkg::S_CMUL;
                        mpss_pkg::KIND_TRI:    n_state = mpss_pkg::S_SETUP;
                        default:               n_state = mpss_pkg::S_UPDATE;
                    endcase
                end
            end
            mpss_pkg::S_RECT:  n_state = mpss_pkg::S_UPDATE;
            mpss_pkg::S_CMUL:  n_state = mpss_pkg::S_CDIV;
            mpss_pkg::S_CDIV:  n_state = mpss_pkg::S_CEND;
            mpss_pkg::S_CEND:  n_state = mpss_pkg::S_UPDATE;
            mpss_pkg::S_SETUP: n_state = mpss_pkg::S_SQX;
            mpss_pkg::S_SQX:   n_state = mpss_pkg::S_SQY;
            mpss_pkg::S_SQY:   n_state = mpss_pkg::S_ROOT;
            mpss_pkg::S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = mpss_pkg::S_ACC;
                end
            end
            mpss_pkg::S_ACC: begin
                if (i_sts.side_done) begin
                    n_state = mpss_pkg::S_UPDATE;
                end else begin
                    n_state = mpss_pkg::S_SETUP;
                end
            end
            mpss_pkg::S_UPDATE: begin
                if (i_sts.last) begin
                    n_state = mpss_pkg::S_EMIT;
                end else begin
                    n_state = mpss_pkg::S_IDLE;
                end
            end
            mpss_pkg::S_EMIT: begin
                if (can_emit) begin
                    n_state = mpss_pkg::S_IDLE;
                end
            end
            default: n_state = mpss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            mpss_pkg::S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            mpss_pkg::S_RECT:   o_cmd.rect      = 1'b1;
            mpss_pkg::S_CMUL:   o_cmd.cmul      = 1'b1;
            mpss_pkg::S_CDIV:   o_cmd.div_step  = 1'b1;
            mpss_pkg::S_CEND:   o_cmd.div_end   = 1'b1;
            mpss_pkg::S_SETUP:  o_cmd.tri_setup = 1'b1;
            mpss_pkg::S_SQX:    o_cmd.sq_x      = 1'b1;
            mpss_pkg::S_SQY:    o_cmd.sq_y      = 1'b1;
            mpss_pkg::S_ROOT:   o_cmd.root_step = 1'b1;
            mpss_pkg::S_ACC:    o_cmd.acc_side  = 1'b1;
            mpss_pkg::S_UPDATE: o_cmd.update    = 1'b1;
            mpss_pkg::S_EMIT:   o_cmd.emit      = can_emit;
            default: o_cmd = '0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

[rtl/mpss_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpss_dp
// Datapath: shape registers, one 16x16 squarer, a reciprocal multiply for the
// circle constant, a shared one-bit-per-step square root, running maximum.
// ----------------------------------------------------------------------------
module mpss_dp #(
    parameter int MAX_ITEMS = mpss_pkg::MAX_ITEMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mpss_pkg::t_cmd                       i_cmd,
    input  logic [mpss_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tlast,
    output mpss_pkg::t_sts                       o_sts,
    output logic [mpss_pkg::INDEX_W-1:0]         o_winner_index,
    output logic [mpss_pkg::PERIM_W-1:0]         o_winner_perimeter,
    output logic                                 o_found
);

    localparam int CW        = mpss_pkg::COORD_W;
    localparam int PW        = mpss_pkg::PERIM_W;
    localparam int POS_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int IDX_EXT_W = (POS_W > mpss_pkg::INDEX_W) ? POS_W : mpss_pkg::INDEX_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_ITEMS - 1);

    function automatic logic [CW-1:0] f_abs_diff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = (CW+1)'(a) - (CW+1)'(b);
        if (d < 0) begin
            return CW'(-d);
        end
        return CW'(d);
    endfunction

    // captured shape
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [CW-1:0]        r_rad;
    logic                 r_last;

    logic [1:0]                       r_side;
    logic [mpss_pkg::ITER_W-1:0]      r_iter;
    logic [CW-1:0]                    r_dx, r_dy;
    logic [2*CW-1:0]                  r_d2;
    logic [PW-1:0]                    r_cbase;
    logic [mpss_pkg::CFRAC_W-1:0]     r_cfrac;
    logic [mpss_pkg::CQ_W-1:0]        r_cq;
    logic [mpss_pkg::RAD_W-1:0]       r_rad_sh;
    logic [mpss_pkg::SQ_REM_W-1:0]    r_rem;
    logic [mpss_pkg::ROOT_W-1:0]      r_root;
    logic [PW-1:0]                    r_perim;

    // running state
    logic [PW-1:0]    r_max;
    logic [POS_W-1:0] r_best;
    logic             r_have;
    logic [POS_W-1:0] r_pos;

    logic [mpss_pkg::INDEX_W-1:0] r_o_index;
    logic [PW-1:0]                r_o_perim;
    logic                         r_o_found;

    logic signed [CW-1:0] ax, ay, bx, by;
    logic [CW:0]          rect_sum;
    logic [PW-1:0]                   circ_base;
    logic [mpss_pkg::CFRAC_W-1:0]    circ_frac;
    logic [mpss_pkg::CPROD_W-1:0]    circ_prod;
    logic [CW-1:0]                   mul_a;
    logic [2*CW-1:0]                 sq;
    logic [mpss_pkg::D2_W-1:0]       d2_sum;
    logic [mpss_pkg::SQ_REM_W+1:0]   rem_t;
    logic [mpss_pkg::SQ_REM_W+1:0]   trial;
    logic                            root_ge;
    logic [mpss_pkg::SQ_REM_W-1:0]   n_rem;
    logic [mpss_pkg::ROOT_W-1:0]     n_root;
    logic [IDX_EXT_W-1:0]            best_ext;

    // vertex pair of the current triangle side
    always_comb begin
        case (r_side)
            2'd0: begin
                ax = r_x1; ay = r_y1; bx = r_x2; by = r_y2;
            end
            2'd1: begin
                ax = r_x0; ay = r_y0; bx = r_x2; by = r_y2;
            end
            default: begin
                ax = r_x0; ay = r_y0; bx = r_x1; by = r_y1;
            end
        endcase
    end

    assign rect_sum = {1'b0, f_abs_diff(r_x0, r_x1)} + {1'b0, f_abs_diff(r_y0, r_y1)};

    // integer part of the circle product and the numerator of its rounded fraction
    assign circ_base = PW'(r_rad) * PW'(mpss_pkg::CIRC_INT);
    assign circ_frac = mpss_pkg::CFRAC_W'(r_rad) * mpss_pkg::CFRAC_W'(mpss_pkg::CIRC_FRAC_MUL)
                     + mpss_pkg::CFRAC_W'(mpss_pkg::CIRC_FRAC_RND);
    // divide by 125 as multiply by the scaled reciprocal, quotient in the top bits
    assign circ_prod = mpss_pkg::CPROD_W'(r_cfrac) * mpss_pkg::CPROD_W'(mpss_pkg::CIRC_RECIP);

    assign mul_a  = i_cmd.sq_x ? r_dx : r_dy;
    assign sq     = mul_a * mul_a;
    assign d2_sum = mpss_pkg::D2_W'(r_d2) + mpss_pkg::D2_W'(sq);

    // digit-by-digit root, two radicand bits per step
    assign rem_t   = {r_rem, r_rad_sh[mpss_pkg::RAD_W-1 -: 2]};
    assign trial   = (mpss_pkg::SQ_REM_W+2)'({r_root, 2'b01});
    assign root_ge = rem_t >= trial;
    assign n_rem   = root_ge ? mpss_pkg::SQ_REM_W'(rem_t - trial)
                             : mpss_pkg::SQ_REM_W'(rem_t);
    assign n_root  = {r_root[mpss_pkg::ROOT_W-2:0], root_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0    <= i_s_tdata[0*CW +: CW];
            r_y0    <= i_s_tdata[1*CW +: CW];
            r_x1    <= i_s_tdata[2*CW +: CW];
            r_y1    <= i_s_tdata[3*CW +: CW];
            r_x2    <= i_s_tdata[4*CW +: CW];
            r_y2    <= i_s_tdata[5*CW +: CW];
            r_rad   <= i_s_tdata[6*CW +: CW];
            r_last  <= i_s_tlast;
            r_side  <= 2'd0;
            r_perim <= '0;
        end
        if (i_cmd.rect) begin
            r_perim <= {1'b0, rect_sum, 9'b0};
        end
        if (i_cmd.cmul) begin
            r_cbase <= circ_base;
            r_cfrac <= circ_frac;
        end
        if (i_cmd.div_step) begin
            r_cq <= circ_prod[mpss_pkg::CPROD_W-1 -: mpss_pkg::CQ_W];
        end
        if (i_cmd.div_end) begin
            r_perim <= r_cbase + PW'(r_cq);
        end
        if (i_cmd.tri_setup) begin
            r_dx <= f_abs_diff(ax, bx);
            r_dy <= f_abs_diff(ay, by);
        end
        if (i_cmd.sq_x) begin
            r_d2 <= sq;
        end
        if (i_cmd.sq_y) begin
            r_rad_sh <= {1'b0, d2_sum, 16'b0};
            r_rem    <= '0;
            r_root   <= '0;
            r_iter   <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad_sh <= {r_rad_sh[mpss_pkg::RAD_W-3:0], 2'b00};
            r_rem    <= n_rem;
            r_root   <= n_root;
            r_iter   <= r_iter + 1'b1;
        end
        if (i_cmd.acc_side) begin
            r_perim <= r_perim + PW'(r_root);
            r_side  <= r_side + 2'd1;
        end
        if (i_cmd.emit) begin
            r_o_index <= best_ext[mpss_pkg::INDEX_W-1:0];
            r_o_perim <= r_max;
            r_o_found <= r_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= '0;
            r_best <= '0;
            r_have <= 1'b0;
            r_pos  <= '0;
        end else if (i_cmd.emit) begin
            r_max  <= '0;
            r_best <= '0;
            r_have <= 1'b0;
            r_pos  <= '0;
        end else if (i_cmd.update) begin
            // strict compare keeps the earlier shape on a tie
            if (r_perim > r_max) begin
                r_max  <= r_perim;
                r_best <= r_pos;
                r_have <= 1'b1;
            end
            if (r_pos != POS_LAST) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    assign best_ext = IDX_EXT_W'(r_best);

    assign o_sts.last      = r_last;
    assign o_sts.root_done = (r_iter == mpss_pkg::ITER_W'(mpss_pkg::SQRT_STEPS - 1));
    assign o_sts.side_done = (r_side == 2'd2);

    assign o_winner_index     = r_o_index;
    assign o_winner_perimeter = r_o_perim;
    assign o_found            = r_o_found;

endmodule

[rtl/max_perimeter_shape_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_perimeter_shape_select
// Finds the shape with the largest perimeter in a list of shapes.
// ----------------------------------------------------------------------------
// Input stream: one shape per request. tuser carries the shape kind
// (rectangle, circle, triangle, or unused), tdata the six coordinates and
// the radius, tlast marks the final shape of a list.
// Output stream: one request per list, sent after the shape marked last:
// winner index and perimeter (Q.8) in tdata, found flag in tuser.
// Shapes are taken one at a time. After the accept, a rectangle sums its
// sides, a circle runs constant multiplies, then a reciprocal multiply for
// the rounding divide, a triangle runs three sides through the one shared
// square-root unit, 25 steps each; an unused kind goes straight to the update.
// After the last shape of a list, an emit state loads the output register.
// The result sits in an output register; the next list's shapes are taken
// while it waits. If the receiver stalls and a second result is ready,
// input stops until the first one is taken.
// Reset clears the running maximum, the position count and the output
// valid. Positions saturate at MAX_ITEMS - 1.
// ----------------------------------------------------------------------------
module max_perimeter_shape_select #(
    parameter int MAX_ITEMS = mpss_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, radius (16 bits each)
    input  logic [mpss_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // shape_kind
    input  logic [1:0]                        i_s_tuser,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // winner_index (12), winner_perimeter (27), zero pad (1)
    output logic [mpss_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // found
    output logic                              o_m_tuser
);

    mpss_pkg::t_cmd cmd;
    mpss_pkg::t_sts sts;

    logic [mpss_pkg::INDEX_W-1:0] winner_index;
    logic [mpss_pkg::PERIM_W-1:0] winner_perimeter;

    mpss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_kind   (mpss_pkg::t_kind'(i_s_tuser)),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    mpss_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_s_tdata          (i_s_tdata),
        .i_s_tlast          (i_s_tlast),
        .o_sts              (sts),
        .o_winner_index     (winner_index),
        .o_winner_perimeter (winner_perimeter),
        .o_found            (o_m_tuser)
    );

    assign o_m_tdata = {1'b0, winner_perimeter, winner_index};

endmodule

[rtl/mpss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpss_checker
// Port-level checks for the shape perimeter maximum selector.
// ----------------------------------------------------------------------------
module mpss_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mpss_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    // no winner reports zero index and perimeter
    a_no_winner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == '0)
        else $error("result without winner has nonzero fields");

    // a winner has a positive perimeter
    a_winner_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser
            |-> i_m_tdata[mpss_pkg::INDEX_W +: mpss_pkg::PERIM_W] != '0)
        else $error("winner with zero perimeter");

    // shapes are never taken back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("request taken on back-to-back cycles");

endmodule

bind max_perimeter_shape_select mpss_checker u_mpss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
